@@ hw/rtl/aes_ctr_pkg.sv @@
// shared types, constants and aes byte functions for the ctr block
// no dependencies
package aes_ctr_pkg;

  typedef enum logic [1:0] {
    CMD_PROCESS = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ADDR_IV_HIGH   = 3'd0,
    ADDR_IV_LOW    = 3'd1,
    ADDR_START     = 3'd2,
    ADDR_LIMIT     = 3'd3,
    ADDR_ROUNDS    = 3'd4
  } reg_addr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_REQ,
    ST_INIT,
    ST_ROUND,
    ST_FINISH,
    ST_OUT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic       key_rd;     // fetch round key words for key_round
    logic [3:0] key_round;
    logic       init;       // load counter block xor key 0
    logic       round;      // one round with mixcolumns
    logic       last;       // final round without mixcolumns
    logic       finish;     // form result
    logic       refuse;     // form error result
    logic       bump;       // advance counter
  } dp_cmd_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

endpackage

@@ hw/rtl/aes_ctr_round.sv @@
// one aes round: subbytes, shiftrows, optional mixcolumns, addroundkey
// depends on aes_ctr_pkg
module aes_ctr_round (
  input  logic [127:0] state_in,
  input  logic [127:0] round_key,
  input  logic         last,
  output logic [127:0] state_out
);
  import aes_ctr_pkg::*;

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_in[127-8*i -: 8];
    end
    for (int row = 0; row < 4; row++) begin
      for (int col = 0; col < 4; col++) begin
        t[row+4*col] = SBOX[s[row+4*((col+row)%4)]];
      end
    end
    for (int col = 0; col < 4; col++) begin
      m[4*col]   = xtime(t[4*col]) ^ xtime(t[4*col+1]) ^ t[4*col+1] ^ t[4*col+2] ^ t[4*col+3];
      m[4*col+1] = t[4*col] ^ xtime(t[4*col+1]) ^ xtime(t[4*col+2]) ^ t[4*col+2] ^ t[4*col+3];
      m[4*col+2] = t[4*col] ^ t[4*col+1] ^ xtime(t[4*col+2]) ^ xtime(t[4*col+3]) ^ t[4*col+3];
      m[4*col+3] = xtime(t[4*col]) ^ t[4*col] ^ t[4*col+1] ^ t[4*col+2] ^ xtime(t[4*col+3]);
    end
    for (int i = 0; i < 16; i++) begin
      state_out[127-8*i -: 8] = (last ? t[i] : m[i]) ^ round_key[127-8*i -: 8];
    end
  end
endmodule

@@ hw/rtl/aes_ctr_datapath.sv @@
// datapath: key store memory, counter, state register, round unit, output register
// depends on aes_ctr_pkg and aes_ctr_round
module aes_ctr_datapath #(
  parameter int KEY_STORE_WORDS = 30
) (
  input  logic                 clk,
  input  logic                 rst,
  input  aes_ctr_pkg::dp_cmd_t cmd,
  input  logic                 key_we,
  input  logic [4:0]           key_idx,
  input  logic [63:0]          key_data,
  input  logic                 restart,
  input  logic [63:0]          iv_high_lane,
  input  logic [63:0]          iv_low_lane,
  input  logic [63:0]          start_counter,
  input  logic [63:0]          counter_limit,
  input  logic [63:0]          data_high,
  input  logic [63:0]          data_low,
  input  logic                 data_load,
  output logic                 exhausted,
  output logic [63:0]          result_high,
  output logic [63:0]          result_low,
  output logic                 status
);
  import aes_ctr_pkg::*;

  localparam int KIW = $clog2(KEY_STORE_WORDS);

  logic [63:0]  key_mem [KEY_STORE_WORDS];
  logic [63:0]  key_hi;
  logic [63:0]  key_lo;
  logic         hi_ok;
  logic         lo_ok;
  logic [5:0]   hi_addr;
  logic [5:0]   lo_addr;
  logic [63:0]  block_counter;
  logic [127:0] aes_state;
  logic [127:0] round_out;
  logic [127:0] round_key;
  logic [127:0] data_reg;

  assign hi_addr = {1'b0, cmd.key_round, 1'b0};
  assign lo_addr = {1'b0, cmd.key_round, 1'b1};

  // two read ports, registered data; words beyond the store read zero
  always_ff @(posedge clk) begin
    if (key_we && ({1'b0, key_idx} < 6'(KEY_STORE_WORDS))) begin
      key_mem[key_idx[KIW-1:0]] <= key_data;
    end
    if (cmd.key_rd) begin
      key_hi <= key_mem[hi_addr[KIW-1:0]];
      key_lo <= key_mem[lo_addr[KIW-1:0]];
      hi_ok  <= hi_addr < 6'(KEY_STORE_WORDS);
      lo_ok  <= lo_addr < 6'(KEY_STORE_WORDS);
    end
  end

  assign round_key = {hi_ok ? key_hi : 64'd0, lo_ok ? key_lo : 64'd0};
  assign exhausted = block_counter >= counter_limit;

  aes_ctr_round u_round (
    .state_in  (aes_state),
    .round_key (round_key),
    .last      (cmd.last),
    .state_out (round_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
    end else if (restart) begin
      block_counter <= start_counter;
    end else if (cmd.bump) begin
      block_counter <= block_counter + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (data_load) begin
      data_reg <= {data_high, data_low};
    end
    if (cmd.init) begin
      aes_state <= {iv_high_lane, iv_low_lane ^ block_counter} ^ round_key;
    end else if (cmd.round || cmd.last) begin
      aes_state <= round_out;
    end
    if (cmd.finish) begin
      {result_high, result_low} <= data_reg ^ aes_state;
      status <= 1'b0;
    end else if (cmd.refuse) begin
      result_high <= '0;
      result_low  <= '0;
      status      <= 1'b1;
    end
  end
endmodule

@@ hw/rtl/aes_ctr_ctrl.sv @@
// controller state machine sequencing key fetch, rounds and the output handshake
// depends on aes_ctr_pkg
module aes_ctr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic [1:0]           command,
  input  logic [3:0]           round_count,
  input  logic                 exhausted,
  input  logic                 out_ready,
  output logic                 in_ready,
  output logic                 out_valid,
  output aes_ctr_pkg::dp_cmd_t cmd
);
  import aes_ctr_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [3:0] rnd;
  logic [3:0] rnd_next;
  logic [3:0] nr;
  logic       pending;
  logic       pending_next;

  assign nr = (round_count >= 4'd14) ? 4'd14 : ((round_count >= 4'd12) ? 4'd12 : 4'd10);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rnd     <= '0;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      rnd     <= rnd_next;
      pending <= pending_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    rnd_next   = rnd;
    case (state)
      ST_IDLE: begin
        if (in_fire && (command == CMD_PROCESS)) begin
          state_next = exhausted ? ST_OUT : ST_KEY_REQ;
          rnd_next   = '0;
        end
      end
      ST_KEY_REQ: begin
        state_next = (rnd == 4'd0) ? ST_INIT : ST_ROUND;
      end
      ST_INIT, ST_ROUND: begin
        rnd_next   = rnd + 4'd1;
        state_next = (rnd == nr) ? ST_FINISH : ST_KEY_REQ;
      end
      ST_FINISH: state_next = ST_OUT;
      ST_OUT: begin
        if (!pending || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.key_round = rnd;
    pending_next = pending && !out_ready;
    in_ready     = (state == ST_IDLE) && !pending;
    case (state)
      ST_IDLE: begin
        if (in_fire && (command == CMD_PROCESS)) begin
          cmd.refuse   = exhausted;
          pending_next = exhausted;
        end
      end
      ST_KEY_REQ: cmd.key_rd = 1'b1;
      ST_INIT:    cmd.init = 1'b1;
      ST_ROUND: begin
        cmd.round = (rnd != nr);
        cmd.last  = (rnd == nr);
      end
      ST_FINISH: begin
        cmd.finish   = 1'b1;
        cmd.bump     = 1'b1;
        pending_next = 1'b1;
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  assign out_valid = pending;
endmodule

@@ hw/rtl/aes_ctr_block_cipher.sv @@
// aes counter mode engine over whole 16-byte blocks, top level
// results: a block's result is registered in the finish step after its last round; a refused
// block gives its result in the cycle after it is taken; load and restart give no result
// flow: one item at a time, a new one once the last result is taken; a load or restart every
// cycle while no result is pending; each round fetches its key from the store the cycle before
// reset (rst, synchronous): counter zero, limit all ones, 10 rounds; key store undefined
// depends on aes_ctr_pkg, aes_ctr_ctrl, aes_ctr_datapath
module aes_ctr_block_cipher #(
  parameter int KEY_STORE_WORDS = 30
) (
  input  logic        clk,
  input  logic        rst,
  // input item channel
  input  logic        valid,
  output logic        ready,
  input  logic [1:0]  command,
  input  logic [4:0]  key_word_index,
  input  logic [63:0] data_high,
  input  logic [63:0] data_low,
  // result item channel
  output logic        result_valid,
  input  logic        result_ready,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  output logic        status,
  // configuration port, registers at 8-byte spacing
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import aes_ctr_pkg::*;

  logic [63:0] iv_high_lane;
  logic [63:0] iv_low_lane;
  logic [63:0] start_counter;
  logic [63:0] counter_limit;
  logic [3:0]  round_count;
  logic        in_fire;
  logic        cfg_we;
  logic        exhausted;
  dp_cmd_t     cmd;
  reg_addr_t   reg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = reg_addr_t'(paddr[5:3]);
  assign in_fire = valid && ready;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      iv_high_lane  <= '0;
      iv_low_lane   <= '0;
      start_counter <= '0;
      counter_limit <= '1;
      round_count   <= 4'd10;
    end else if (cfg_we && (paddr[2:0] == 3'd0)) begin
      case (reg_sel)
        ADDR_IV_HIGH: iv_high_lane  <= pwdata;
        ADDR_IV_LOW:  iv_low_lane   <= pwdata;
        ADDR_START:   start_counter <= pwdata;
        ADDR_LIMIT:   counter_limit <= pwdata;
        ADDR_ROUNDS:  round_count   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      ADDR_IV_HIGH: prdata = iv_high_lane;
      ADDR_IV_LOW:  prdata = iv_low_lane;
      ADDR_START:   prdata = start_counter;
      ADDR_LIMIT:   prdata = counter_limit;
      ADDR_ROUNDS:  prdata = {60'd0, round_count};
      default:      prdata = '0;
    endcase
  end

  aes_ctr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .command     (command),
    .round_count (round_count),
    .exhausted   (exhausted),
    .out_ready   (result_ready),
    .in_ready    (ready),
    .out_valid   (result_valid),
    .cmd         (cmd)
  );

  aes_ctr_datapath #(
    .KEY_STORE_WORDS (KEY_STORE_WORDS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .key_we        (in_fire && (command == CMD_LOAD)),
    .key_idx       (key_word_index),
    .key_data      (data_low),
    .restart       (in_fire && (command == CMD_RESTART)),
    .iv_high_lane  (iv_high_lane),
    .iv_low_lane   (iv_low_lane),
    .start_counter (start_counter),
    .counter_limit (counter_limit),
    .data_high     (data_high),
    .data_low      (data_low),
    .data_load     (in_fire),
    .exhausted     (exhausted),
    .result_high   (result_high),
    .result_low    (result_low),
    .status        (status)
  );
endmodule

@@ dv/tb.sv @@
// testbench for aes_ctr_block_cipher: directed and random items checked against a
// behavioral aes counter-mode predictor kept inside this file
// depends on aes_ctr_pkg and the rtl of aes_ctr_block_cipher
`timescale 1ns / 100ps

module tb;
  import aes_ctr_pkg::*;

  localparam int KEY_WORDS = 30;
  localparam int SETTLE_CYCLES = 40;     // quiet time after the last result, longer than the longest block at 14 rounds
  localparam int STALL_LIMIT = 4000;     // cycles with no handshake before giving up
  localparam int HOLD_CYCLES = 300;      // long receiver hold-off

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        st;
  } cipher_out_t;

  logic clk, rst;
  logic valid, ready;
  logic [1:0] command;
  logic [4:0] key_word_index;
  logic [63:0] data_high, data_low;
  logic result_valid, result_ready;
  logic [63:0] result_high, result_low;
  logic status;
  logic psel, penable, pwrite, pready;
  logic [5:0] paddr;
  logic [63:0] pwdata, prdata;

  aes_ctr_block_cipher dut (
    .clk(clk), .rst(rst),
    .valid(valid), .ready(ready), .command(command), .key_word_index(key_word_index),
    .data_high(data_high), .data_low(data_low),
    .result_valid(result_valid), .result_ready(result_ready),
    .result_high(result_high), .result_low(result_low), .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of the block's registers and state
  logic [63:0] iv_hi_q, iv_lo_q, start_q, limit_q, ctr_q;
  logic [3:0]  rounds_q;
  logic [63:0] key_mem [KEY_WORDS];

  cipher_out_t pending_blocks[$];
  int mismatches, blocks_seen, refusals_seen;
  bit steady;            // no idling on either side
  bit hold_req;          // ask the receiver for a long hold-off
  int hold_left;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // aes predictor, bytes kept with index 0 as the most significant byte
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b = b >> 1;
    end
    return p;
  endfunction

  // inverse as x^254, then the affine map
  function automatic logic [7:0] sub_byte(input logic [7:0] x);
    logic [7:0] r, b;
    r = 8'h01;
    b = x;
    for (int e = 254; e > 0; e = e >> 1) begin
      if (e[0]) r = gmul(r, b);
      b = gmul(b, b);
    end
    if (x == 8'h00) r = 8'h00;
    return r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^ {r[3:0], r[7:4]} ^ 8'h63;
  endfunction

  function automatic logic [127:0] round_key(input int r);
    return {key_mem[2*r], key_mem[2*r+1]};
  endfunction

  function automatic logic [127:0] encrypt_block(input logic [127:0] blk, input int nr);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] v;
    v = blk ^ round_key(0);
    for (int r = 1; r <= nr; r++) begin
      for (int k = 0; k < 16; k++) s[k] = v[127-8*k -: 8];
      // sub bytes and shift rows
      for (int row = 0; row < 4; row++)
        for (int col = 0; col < 4; col++)
          t[row+4*col] = sub_byte(s[row + 4*((col+row) & 3)]);
      if (r != nr) begin
        for (int col = 0; col < 4; col++) begin
          a0 = t[4*col]; a1 = t[4*col+1]; a2 = t[4*col+2]; a3 = t[4*col+3];
          t[4*col]   = gmul(a0, 8'd2) ^ gmul(a1, 8'd3) ^ a2 ^ a3;
          t[4*col+1] = a0 ^ gmul(a1, 8'd2) ^ gmul(a2, 8'd3) ^ a3;
          t[4*col+2] = a0 ^ a1 ^ gmul(a2, 8'd2) ^ gmul(a3, 8'd3);
          t[4*col+3] = gmul(a0, 8'd3) ^ a1 ^ a2 ^ gmul(a3, 8'd2);
        end
      end
      for (int k = 0; k < 16; k++) v[127-8*k -: 8] = t[k];
      v = v ^ round_key(r);
    end
    return v;
  endfunction

  // update the predicted state for one accepted item, queue its result if any
  function automatic void predict_item(input logic [1:0] c, input logic [4:0] idx,
                                       input logic [63:0] hi, input logic [63:0] lo);
    cipher_out_t o;
    logic [127:0] ks;
    int nr;
    case (c)
      CMD_LOAD: begin
        if (idx < KEY_WORDS) key_mem[idx] = lo;
      end
      CMD_RESTART: begin
        ctr_q = start_q;
      end
      CMD_PROCESS: begin
        if (ctr_q >= limit_q) begin
          o.hi = '0; o.lo = '0; o.st = 1'b1;
        end else begin
          nr = (rounds_q >= 14) ? 14 : ((rounds_q >= 12) ? 12 : 10);
          ks = encrypt_block({iv_hi_q, iv_lo_q ^ ctr_q}, nr);
          o.hi = hi ^ ks[127:64]; o.lo = lo ^ ks[63:0]; o.st = 1'b0;
          ctr_q = ctr_q + 64'd1;
        end
        pending_blocks.push_back(o);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checker and receiver idling
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cipher_out_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h %h st=%b",
                                       result_high, result_low, status);
      end else begin
        want = pending_blocks.pop_front();
        if (want.st) refusals_seen++; else blocks_seen++;
        if (result_high !== want.hi || result_low !== want.lo || status !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: exp %h %h st=%b got %h %h st=%b",
                     want.hi, want.lo, want.st, result_high, result_low, status);
        end
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left--;
    end else begin
      result_ready <= steady ? 1'b1 : ($urandom_range(99) >= 24);
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if ((valid && ready) || (result_valid && result_ready) || (psel && penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress, %0d results outstanding", pending_blocks.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers, all called on a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_item(input cmd_t c, input logic [4:0] idx,
                           input logic [63:0] hi, input logic [63:0] lo);
    int gap;
    gap = (!steady && $urandom_range(99) < 24) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    valid <= 1'b1;
    command <= c;
    key_word_index <= idx;
    data_high <= hi;
    data_low <= lo;
    do @(posedge clk); while (!(valid && ready));
    predict_item(c, idx, hi, lo);
  endtask

  // sender pause until every result is back, then let the block go quiet
  task automatic drain;
    valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup and access phases, then an idle step so back-to-back writes never overlap
  task automatic write_reg(input reg_addr_t a, input logic [63:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {a, 3'b000}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    case (a)
      ADDR_IV_HIGH: iv_hi_q = v;
      ADDR_IV_LOW:  iv_lo_q = v;
      ADDR_START:   start_q = v;
      ADDR_LIMIT:   limit_q = v;
      ADDR_ROUNDS:  rounds_q = v[3:0];
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic process_rand();
    send_item(CMD_PROCESS, 5'($urandom), rand64(), rand64());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every key slot written before any block reads it; slots past the store are ignored
  task automatic test_key_load;
    for (int i = 0; i < KEY_WORDS; i++) send_item(CMD_LOAD, 5'(i), rand64(), rand64());
    send_item(CMD_LOAD, 5'd30, rand64(), '1);
    send_item(CMD_LOAD, 5'd31, rand64(), '0);
  endtask

  // data extremes, unused command, restart, counter exhaustion
  task automatic test_directed;
    send_item(CMD_PROCESS, 5'd0, '0, '0);
    send_item(CMD_PROCESS, 5'd31, '1, '1);
    send_item(CMD_NONE, 5'd7, '1, '1);
    send_item(CMD_PROCESS, 5'd0, 64'h0123456789abcdef, 64'hfedcba9876543210);
    drain();
    write_reg(ADDR_START, 64'd5);
    write_reg(ADDR_LIMIT, 64'd7);
    send_item(CMD_RESTART, 5'd0, '0, '0);
    // two blocks pass, then refusals with the counter held
    repeat (4) process_rand();
    send_item(CMD_RESTART, 5'd0, '0, '0);
    process_rand();
    drain();
    write_reg(ADDR_LIMIT, 64'd0);
    repeat (2) process_rand();
    drain();
    // top of the counter range with all-ones iv
    write_reg(ADDR_IV_HIGH, '1);
    write_reg(ADDR_IV_LOW, '1);
    write_reg(ADDR_START, 64'hffff_ffff_ffff_fffd);
    write_reg(ADDR_LIMIT, '1);
    send_item(CMD_RESTART, 5'd0, '0, '0);
    repeat (3) process_rand();
    drain();
  endtask

  // round-count codes 0 and 9 to 15, including the ones folded to 10, 12 and 14
  task automatic test_round_counts;
    logic [3:0] codes [8] = '{4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15, 4'd0, 4'd9};
    write_reg(ADDR_IV_HIGH, rand64());
    write_reg(ADDR_IV_LOW, '0);
    write_reg(ADDR_START, '0);
    send_item(CMD_RESTART, 5'd0, '0, '0);
    drain();
    foreach (codes[i]) begin
      write_reg(ADDR_ROUNDS, {60'd0, codes[i]});
      repeat (2) process_rand();
      drain();
    end
  endtask

  // receiver holds off while the sender keeps offering blocks
  task automatic test_backpressure;
    write_reg(ADDR_ROUNDS, 64'd10);
    write_reg(ADDR_LIMIT, '1);
    hold_req = 1'b1;
    steady = 1'b1;
    repeat (20) process_rand();
    steady = 1'b0;
    drain();
  endtask

  // random phases with fresh settings; one phase runs with no idling
  task automatic test_random;
    int pick;
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(ADDR_IV_HIGH, rand64());
      write_reg(ADDR_IV_LOW, ($urandom_range(1) == 1) ? rand64() : {rand64()} & ~64'hffff);
      write_reg(ADDR_START, ($urandom_range(3) == 0) ? ~64'($urandom_range(200)) : rand64());
      write_reg(ADDR_LIMIT, ($urandom_range(1) == 1) ? '1 : start_q + $urandom_range(0, 120));
      write_reg(ADDR_ROUNDS, 64'($urandom_range(15)));
      steady = (ph == 2);
      send_item(CMD_RESTART, 5'($urandom), rand64(), rand64());
      for (int n = 0; n < 85; n++) begin
        pick = $urandom_range(99);
        if (pick < 75) process_rand();
        else if (pick < 87) send_item(CMD_LOAD, 5'($urandom), rand64(), rand64());
        else if (pick < 94) send_item(CMD_RESTART, 5'($urandom), rand64(), rand64());
        else send_item(CMD_NONE, 5'($urandom), rand64(), rand64());
      end
      steady = 1'b0;
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    valid = 1'b0; command = CMD_NONE; key_word_index = '0;
    data_high = '0; data_low = '0;
    result_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    iv_hi_q = '0; iv_lo_q = '0; start_q = '0; limit_q = '1; ctr_q = '0; rounds_q = 4'd10;
    foreach (key_mem[i]) key_mem[i] = '0;
    mismatches = 0; blocks_seen = 0; refusals_seen = 0;
    steady = 1'b0; hold_req = 1'b0; hold_left = 0; stall_cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_key_load();
    test_directed();
    test_round_counts();
    test_backpressure();
    test_random();

    $display("covered %0d encrypted blocks and %0d refused blocks over all round counts,",
             blocks_seen, refusals_seen);
    $display("key loads, counter restarts, limits and receiver/sender stalls");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
